// ===== rtl/core/spg_pkg.sv =====
// Shared types, constants and helpers of the seeded position generator.
// No dependencies; used by every module of the block.
package spg_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;
    localparam int KEY_W       = 144;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [63:0] HASH_BASIS    = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME_LO = 64'h00000000000001b3;
    localparam int          HASH_SHIFT    = 40;
    localparam int          HASH_STEPS    = 18;

    localparam logic [63:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2    = 64'h94d049bb133111eb;
    localparam int          MIX_SH0   = 30;
    localparam int          MIX_SH1   = 27;
    localparam int          MIX_SH2   = 31;

    localparam int COORD_SPAN = 20001;
    localparam int MOD_STEPS  = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COORD_BOUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RARE_ITEM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_ITEM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ITEMS_AVAIL = 3'd5;

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_HASH    = 4'd2;
    localparam logic [3:0] OP_ADVANCE = 4'd3;
    localparam logic [3:0] OP_MUL_A   = 4'd4;
    localparam logic [3:0] OP_MUL_B   = 4'd5;
    localparam logic [3:0] OP_MUL_C   = 4'd6;
    localparam logic [3:0] OP_MUL_D   = 4'd7;
    localparam logic [3:0] OP_XS27    = 4'd8;
    localparam logic [3:0] OP_XS31    = 4'd9;
    localparam logic [3:0] OP_MOD     = 4'd10;
    localparam logic [3:0] OP_SAVE_X  = 4'd11;
    localparam logic [3:0] OP_EMIT    = 4'd12;
    localparam logic [3:0] OP_REJECT  = 4'd13;

    typedef struct packed {
        logic [4:0]  min_count;
        logic [4:0]  max_count;
        logic [13:0] coord_bound;
        logic [31:0] rare_item;
        logic [31:0] common_item;
        logic        items_available;
    } cfg_t;

    typedef struct packed {
        logic [3:0] op;
        logic       mul_sel;
        logic       first;
        logic       last;
        logic [4:0] entry_number;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // one radix-16 digit of a remainder mod COORD_SPAN, MSB first
    function automatic logic [14:0] mod_step(logic [14:0] rem, logic [3:0] nib);
        logic [18:0] v;
        logic [18:0] r;
        v = {rem, nib};
        r = v;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= 19'(k * COORD_SPAN))
            begin
                r = v - 19'(k * COORD_SPAN);
            end
        end
        return r[14:0];
    endfunction

endpackage

// ===== rtl/core/spg_cfg_regs.sv =====
// Configuration register file of the seeded position generator.
// Depends on spg_pkg.
module spg_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_data,
    output spg_pkg::cfg_t                  cfg
);

    spg_pkg::cfg_t cfg_reg;
    spg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                spg_pkg::REG_MIN_COUNT:   cfg_next.min_count       = cfg_data[4:0];
                spg_pkg::REG_MAX_COUNT:   cfg_next.max_count       = cfg_data[4:0];
                spg_pkg::REG_COORD_BOUND: cfg_next.coord_bound     = cfg_data[13:0];
                spg_pkg::REG_RARE_ITEM:   cfg_next.rare_item       = cfg_data;
                spg_pkg::REG_COMMON_ITEM: cfg_next.common_item     = cfg_data;
                spg_pkg::REG_ITEMS_AVAIL: cfg_next.items_available = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_count       <= 5'd1;
            cfg_reg.max_count       <= 5'd16;
            cfg_reg.coord_bound     <= 14'd10000;
            cfg_reg.rare_item       <= 32'd0;
            cfg_reg.common_item     <= 32'd0;
            cfg_reg.items_available <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/spg_datapath.sv =====
// Datapath: FNV-1a seed hash, SplitMix64 mixer on a shared 32x32 multiplier,
// radix-16 mod-20001 reduction, clamp and the output register. Uses spg_pkg.
module spg_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  spg_pkg::dp_cmd_t                cmd,
    input  spg_pkg::cfg_t                   cfg,
    input  logic [spg_pkg::KEY_W-1:0]       in_keys,
    output spg_pkg::dp_status_t             status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spg_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                            out_rejected,
    output logic                            out_last
);

    logic [spg_pkg::KEY_W-1:0] key_reg;
    logic [63:0]               s_reg;
    logic [63:0]               z_reg;
    logic [63:0]               prod_reg;
    logic [63:0]               acc_reg;
    logic [14:0]               rem_reg;
    logic [14:0]               x_reg;

    logic        out_valid_reg;
    logic        out_rejected_reg;
    logic        out_last_reg;
    logic [4:0]  out_num_reg;
    logic [31:0] out_item_reg;
    logic [14:0] out_x_reg;
    logic [14:0] out_y_reg;

    logic [63:0] hash_x;
    logic [63:0] hash_next;
    logic [63:0] s_adv;
    logic [63:0] mul_const;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_out;
    logic [63:0] acc_hi;
    logic [15:0] coord_diff;
    logic [14:0] coord;
    logic        out_load;

    assign hash_x    = s_reg ^ {56'd0, key_reg[7:0]};
    assign hash_next = (hash_x << spg_pkg::HASH_SHIFT) + (hash_x * spg_pkg::HASH_PRIME_LO);
    assign s_adv     = s_reg + spg_pkg::MIX_GAMMA;

    assign mul_const = cmd.mul_sel ? spg_pkg::MIX_M2 : spg_pkg::MIX_M1;
    assign op_a      = (cmd.op == spg_pkg::OP_MUL_C) ? z_reg[63:32] : z_reg[31:0];
    assign op_b      = (cmd.op == spg_pkg::OP_MUL_B) ? mul_const[63:32] : mul_const[31:0];
    assign mul_out   = {32'd0, op_a} * {32'd0, op_b};
    assign acc_hi    = acc_reg + {prod_reg[31:0], 32'd0};

    // rem - bound never drops below -bound, so only the upper clamp applies
    always_comb
    begin
        coord_diff = {1'b0, rem_reg} - {2'b00, cfg.coord_bound};
        if (rem_reg > {cfg.coord_bound, 1'b0})
        begin
            coord = {1'b0, cfg.coord_bound};
        end
        else
        begin
            coord = coord_diff[14:0];
        end
    end

    assign out_load = (cmd.op == spg_pkg::OP_EMIT) || (cmd.op == spg_pkg::OP_REJECT);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            spg_pkg::OP_LOAD:
            begin
                key_reg <= in_keys;
                s_reg   <= spg_pkg::HASH_BASIS;
            end
            spg_pkg::OP_HASH:
            begin
                key_reg <= {8'd0, key_reg[spg_pkg::KEY_W-1:8]};
                s_reg   <= hash_next;
            end
            spg_pkg::OP_ADVANCE:
            begin
                s_reg <= s_adv;
                z_reg <= s_adv ^ (s_adv >> spg_pkg::MIX_SH0);
            end
            spg_pkg::OP_MUL_A:
            begin
                prod_reg <= mul_out;
            end
            spg_pkg::OP_MUL_B:
            begin
                prod_reg <= mul_out;
                acc_reg  <= prod_reg;
            end
            spg_pkg::OP_MUL_C:
            begin
                prod_reg <= mul_out;
                acc_reg  <= acc_hi;
            end
            spg_pkg::OP_MUL_D:
            begin
                acc_reg <= acc_hi;
            end
            spg_pkg::OP_XS27:
            begin
                z_reg <= acc_reg ^ (acc_reg >> spg_pkg::MIX_SH1);
            end
            spg_pkg::OP_XS31:
            begin
                z_reg   <= acc_reg ^ (acc_reg >> spg_pkg::MIX_SH2);
                rem_reg <= 15'd0;
            end
            spg_pkg::OP_MOD:
            begin
                rem_reg <= spg_pkg::mod_step(rem_reg, z_reg[63:60]);
                z_reg   <= {z_reg[59:0], 4'd0};
            end
            spg_pkg::OP_SAVE_X:
            begin
                x_reg <= coord;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            if (cmd.op == spg_pkg::OP_REJECT)
            begin
                out_rejected_reg <= 1'b1;
                out_last_reg     <= 1'b1;
                out_num_reg      <= 5'd0;
                out_item_reg     <= 32'd0;
                out_x_reg        <= 15'd0;
                out_y_reg        <= 15'd0;
            end
            else
            begin
                out_rejected_reg <= 1'b0;
                out_last_reg     <= cmd.last;
                out_num_reg      <= cmd.entry_number;
                out_item_reg     <= cmd.first ? cfg.rare_item : cfg.common_item;
                out_x_reg        <= x_reg;
                out_y_reg        <= coord;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_rejected    = out_rejected_reg;
    assign out_last        = out_last_reg;
    assign out_data        = {5'd0, out_y_reg, out_x_reg, out_item_reg, out_num_reg};

endmodule

// ===== rtl/core/spg_ctrl.sv =====
// Controller state machine: request check, hash and mixer sequencing, entry
// counting and result hand-off. Drives spg_datapath; uses spg_pkg.
module spg_ctrl
#(
    parameter int MAX_ENTRIES = spg_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_count,
    input  spg_pkg::cfg_t       cfg,
    input  spg_pkg::dp_status_t status,
    output spg_pkg::dp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_REJECT = 4'd1;
    localparam logic [3:0] ST_HASH   = 4'd2;
    localparam logic [3:0] ST_ADV    = 4'd3;
    localparam logic [3:0] ST_MUL_A  = 4'd4;
    localparam logic [3:0] ST_MUL_B  = 4'd5;
    localparam logic [3:0] ST_MUL_C  = 4'd6;
    localparam logic [3:0] ST_MUL_D  = 4'd7;
    localparam logic [3:0] ST_XS27   = 4'd8;
    localparam logic [3:0] ST_XS31   = 4'd9;
    localparam logic [3:0] ST_MOD    = 4'd10;
    localparam logic [3:0] ST_SAVE_X = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    localparam logic [7:0] MAX_E      = 8'(MAX_ENTRIES);
    localparam logic [4:0] HASH_LAST  = 5'(spg_pkg::HASH_STEPS - 1);
    localparam logic [4:0] MOD_LAST   = 5'(spg_pkg::MOD_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] count_reg, count_next;
    logic [4:0] k_reg, k_next;
    logic       phase_reg, phase_next;
    logic       coord_reg, coord_next;

    logic [7:0] hi;
    logic       reject;
    logic [4:0] k_inc;

    assign hi     = ({3'd0, cfg.max_count} > MAX_E) ? MAX_E : {3'd0, cfg.max_count};
    assign reject = (in_count < {3'd0, cfg.min_count}) || (in_count > hi)
                    || !cfg.items_available;
    assign k_inc  = k_reg + 5'd1;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        coord_next = coord_reg;

        cmd.op           = spg_pkg::OP_NONE;
        cmd.mul_sel      = phase_reg;
        cmd.first        = (k_reg == 5'd0);
        cmd.last         = (k_inc == count_reg);
        cmd.entry_number = k_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = spg_pkg::OP_LOAD;
                    if (reject)
                    begin
                        state_next = ST_REJECT;
                    end
                    else if (in_count != 8'd0)
                    begin
                        count_next = in_count[4:0];
                        step_next  = 5'd0;
                        k_next     = 5'd0;
                        coord_next = 1'b0;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_REJECT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = spg_pkg::OP_REJECT;
                    state_next = ST_IDLE;
                end
            end
            ST_HASH:
            begin
                cmd.op    = spg_pkg::OP_HASH;
                step_next = step_reg + 5'd1;
                if (step_reg == HASH_LAST)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.op     = spg_pkg::OP_ADVANCE;
                phase_next = 1'b0;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op     = spg_pkg::OP_MUL_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op     = spg_pkg::OP_MUL_B;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                cmd.op     = spg_pkg::OP_MUL_C;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.op     = spg_pkg::OP_MUL_D;
                state_next = phase_reg ? ST_XS31 : ST_XS27;
            end
            ST_XS27:
            begin
                cmd.op     = spg_pkg::OP_XS27;
                phase_next = 1'b1;
                state_next = ST_MUL_A;
            end
            ST_XS31:
            begin
                cmd.op     = spg_pkg::OP_XS31;
                step_next  = 5'd0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.op    = spg_pkg::OP_MOD;
                step_next = step_reg + 5'd1;
                if (step_reg == MOD_LAST)
                begin
                    state_next = coord_reg ? ST_EMIT : ST_SAVE_X;
                end
            end
            ST_SAVE_X:
            begin
                cmd.op     = spg_pkg::OP_SAVE_X;
                coord_next = 1'b1;
                state_next = ST_ADV;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = spg_pkg::OP_EMIT;
                    coord_next = 1'b0;
                    k_next     = k_inc;
                    state_next = (k_inc == count_reg) ? ST_IDLE : ST_ADV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 5'd0;
            count_reg <= 5'd0;
            k_reg     <= 5'd0;
            phase_reg <= 1'b0;
            coord_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            coord_reg <= coord_next;
        end
    end

endmodule

// ===== rtl/core/seeded_splitmix_position_generator_top.sv =====
// Top level of the seeded position generator: config registers, controller
// and datapath. Depends on spg_pkg, spg_cfg_regs, spg_ctrl and spg_datapath.
//
// Usage: one request item on s_axis gives entry_count result items on m_axis
// (or one rejected item with tuser set). Registers are written over the cfg
// channel (index, data); the user must write them only while the block is
// idle, which the block itself does not enforce. cfg_ready is always high.
// The seed hash folds in one key byte per hash step. An entry is two
// coordinates, x then y, each an advance, two multiplies as partial products
// on one 32x32 multiplier, two xor-shifts, 16 radix-16 mod steps, and then
// a save of x or the emit of the entry. A rejected request goes to the
// reject state and is answered once the output register is free. One
// request is taken at a time: s_axis_tready is high only between requests,
// and a new request is taken while the last result still waits. A stalled
// receiver holds the block at the next finished entry. Reset clears the
// controller and output valid; registers return to their defaults
// (min 1, max 16, bound 10000, items 0, available).
module seeded_splitmix_position_generator_top
#(
    parameter int MAX_ENTRIES = spg_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // room_key[63:0], instance_key[127:64], version_key[143:128],
    // entry_count[151:144]
    input  logic [spg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_number[4:0], item_code[36:5], pos_x[51:37], pos_y[66:52], zero
    output logic [spg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // rejected[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    spg_pkg::cfg_t       cfg;
    spg_pkg::dp_cmd_t    cmd;
    spg_pkg::dp_status_t status;

    spg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spg_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_count (s_axis_tdata[151:144]),
        .cfg      (cfg),
        .status   (status),
        .cmd      (cmd)
    );

    spg_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .in_keys      (s_axis_tdata[spg_pkg::KEY_W-1:0]),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_rejected (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

endmodule

// ===== test/seeded_splitmix_position_generator_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for seeded_splitmix_position_generator_top: FNV-1a seeded SplitMix64 positions,
// checked item by item against an in-bench predictor across several register settings.
// Depends on spg_pkg and the top level of the block.
module seeded_splitmix_position_generator_top_tb;

    localparam int          ENTRY_CAP     = spg_pkg::MAX_ENTRIES_DEF;
    localparam int          SETTLE_CYCLES = 200;
    localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME     = 64'h00000100000001b3;
    localparam logic [63:0] SM_GAMMA      = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1       = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2       = 64'h94d049bb133111eb;
    localparam logic [63:0] POS_SPAN      = 64'd20001;

    // indexes with no register behind them
    localparam logic [spg_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [spg_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic [63:0] room_key;
        logic [63:0] instance_key;
        logic [15:0] version_key;
        logic [7:0]  entry_count;
    } spawn_req_t;

    typedef struct {
        logic               rejected;
        logic [4:0]         entry_number;
        logic [31:0]        item_code;
        logic signed [14:0] pos_x;
        logic signed [14:0] pos_y;
        logic               last;
    } spawn_entry_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [spg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [spg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [spg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // register mirror
    logic [4:0]  cfg_min = 5'd1;
    logic [4:0]  cfg_max = 5'd16;
    logic [13:0] cfg_bound = 14'd10000;
    logic [31:0] cfg_rare = '0;
    logic [31:0] cfg_common = '0;
    logic        cfg_avail = 1'b1;

    spawn_req_t   spawn_requests[$];
    spawn_entry_t expected_entries[$];

    int  requests_queued = 0;
    int  requests_taken = 0;
    int  entries_checked = 0;
    int  rejects_seen = 0;
    int  cfg_writes = 0;
    int  failures = 0;
    bit  req_taken = 1'b0;
    bit  rsp_taken = 1'b0;
    int  req_wait = 0;
    int  rsp_stall = 0;
    bit  feed_steady = 1'b0;
    bit  drain_steady = 1'b0;

    seeded_splitmix_position_generator_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [63:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            h = (h ^ ((v >> (8 * i)) & 64'hff)) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic [63:0] splitmix_out(logic [63:0] s);
        logic [63:0] z;
        z = (s ^ (s >> 30)) * SM_MUL1;
        z = (z ^ (z >> 27)) * SM_MUL2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [14:0] clamp_coord(logic [63:0] r);
        logic [63:0] m;
        int b;
        int c;
        b = int'(cfg_bound);
        m = r % POS_SPAN;
        c = int'(m[14:0]) - b;
        if (c < -b)
            c = -b;
        if (c > b)
            c = b;
        return c[14:0];
    endfunction

    function automatic void predict_spawn(spawn_req_t r);
        logic [63:0]  seed;
        logic [4:0]   hi;
        spawn_entry_t e;
        hi = (cfg_max > 5'(ENTRY_CAP)) ? 5'(ENTRY_CAP) : cfg_max;
        if (r.entry_count < cfg_min || r.entry_count > hi || !cfg_avail)
        begin
            e.rejected     = 1'b1;
            e.entry_number = '0;
            e.item_code    = '0;
            e.pos_x        = '0;
            e.pos_y        = '0;
            e.last         = 1'b1;
            expected_entries.insert(expected_entries.size(), e);
            return;
        end
        seed = fnv_fold(FNV_BASIS, r.room_key, 8);
        seed = fnv_fold(seed, r.instance_key, 8);
        seed = fnv_fold(seed, {48'd0, r.version_key}, 2);
        for (int k = 0; k < r.entry_count; k++)
        begin
            e.rejected     = 1'b0;
            e.entry_number = 5'(k + 1);
            e.item_code    = (k == 0) ? cfg_rare : cfg_common;
            seed           = seed + SM_GAMMA;
            e.pos_x        = clamp_coord(splitmix_out(seed));
            seed           = seed + SM_GAMMA;
            e.pos_y        = clamp_coord(splitmix_out(seed));
            e.last         = (k + 1 == r.entry_count);
            expected_entries.insert(expected_entries.size(), e);
        end
    endfunction

    // request side
    always @(negedge clk)
    begin : feed
        spawn_req_t r;
        if (rst_n && !(s_axis_tvalid && !req_taken))
        begin
            if (req_wait != 0)
            begin
                req_wait <= req_wait - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (spawn_requests.size() != 0)
            begin
                r = spawn_requests.pop_front();
                s_axis_tdata <= {r.entry_count, r.version_key, r.instance_key, r.room_key};
                s_axis_tvalid <= 1'b1;
                req_wait <= feed_steady ? 0 : $urandom_range(0, 17);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin : drain
        int n;
        if (rst_n)
        begin
            n = rsp_taken ? (drain_steady ? 0 : $urandom_range(0, 17)) : rsp_stall;
            if (n != 0)
            begin
                m_axis_tready <= 1'b0;
                rsp_stall <= n - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rsp_stall <= 0;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        spawn_req_t   r;
        spawn_entry_t got;
        spawn_entry_t want;
        req_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        rsp_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            r.room_key     = s_axis_tdata[63:0];
            r.instance_key = s_axis_tdata[127:64];
            r.version_key  = s_axis_tdata[143:128];
            r.entry_count  = s_axis_tdata[151:144];
            predict_spawn(r);
            requests_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.rejected     = m_axis_tuser;
            got.entry_number = m_axis_tdata[4:0];
            got.item_code    = m_axis_tdata[36:5];
            got.pos_x        = m_axis_tdata[51:37];
            got.pos_y        = m_axis_tdata[66:52];
            got.last         = m_axis_tlast;
            if (expected_entries.size() == 0)
            begin
                $error("unexpected item: entry_number %0d", got.entry_number);
                failures++;
            end
            else
            begin
                want = expected_entries.pop_front();
                entries_checked++;
                if (got.rejected)
                    rejects_seen++;
                if (got.rejected !== want.rejected)
                begin
                    $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
                    failures++;
                end
                if (got.entry_number !== want.entry_number)
                begin
                    $error("entry_number: expected %0d, got %0d",
                           want.entry_number, got.entry_number);
                    failures++;
                end
                if (got.item_code !== want.item_code)
                begin
                    $error("item_code: expected %h, got %h", want.item_code, got.item_code);
                    failures++;
                end
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                    failures++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                    failures++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    task automatic write_reg(logic [spg_pkg::CFG_IDX_W-1:0] idx,
                             logic [spg_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            spg_pkg::REG_MIN_COUNT:   cfg_min = val[4:0];
            spg_pkg::REG_MAX_COUNT:   cfg_max = val[4:0];
            spg_pkg::REG_COORD_BOUND: cfg_bound = val[13:0];
            spg_pkg::REG_RARE_ITEM:   cfg_rare = val;
            spg_pkg::REG_COMMON_ITEM: cfg_common = val;
            spg_pkg::REG_ITEMS_AVAIL: cfg_avail = val[0];
            default:                  ;
        endcase
        cfg_writes++;
    endtask

    task automatic program_regs(logic [31:0] min_c, logic [31:0] max_c, logic [31:0] bound,
                                logic [31:0] rare, logic [31:0] common, logic [31:0] avail,
                                bit with_spare);
        if (with_spare)
        begin
            write_reg(REG_SPARE_6, $urandom);
            write_reg(REG_SPARE_7, $urandom);
        end
        write_reg(spg_pkg::REG_MIN_COUNT, min_c);
        write_reg(spg_pkg::REG_MAX_COUNT, max_c);
        write_reg(spg_pkg::REG_COORD_BOUND, bound);
        write_reg(spg_pkg::REG_RARE_ITEM, rare);
        write_reg(spg_pkg::REG_COMMON_ITEM, common);
        write_reg(spg_pkg::REG_ITEMS_AVAIL, avail);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_request(logic [63:0] room, logic [63:0] inst, logic [15:0] ver,
                                 logic [7:0] cnt);
        spawn_req_t r;
        r.room_key     = room;
        r.instance_key = inst;
        r.version_key  = ver;
        r.entry_count  = cnt;
        spawn_requests.insert(spawn_requests.size(), r);
        requests_queued++;
    endtask

    function automatic logic [63:0] random_key();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(int n);
        int         sel;
        logic [7:0] cnt;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                cnt = 8'($urandom_range(0, 4));
            else if (sel < 78)
                cnt = 8'($urandom_range(5, 15));
            else if (sel < 85)
                cnt = 8'd16;
            else
                cnt = 8'($urandom_range(0, 255));
            queue_request(random_key(), random_key(), 16'($urandom), cnt);
        end
    endtask

    // all items taken and answered, then room for a request that answers nothing
    task automatic wait_idle();
        @(negedge clk);
        while (requests_taken != requests_queued || expected_entries.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults
        queue_request('0, '0, '0, 8'd0);
        queue_request('0, '0, '0, 8'd1);
        queue_request('1, '1, 16'hffff, 8'd16);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd17);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd255);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd2);
        wait_idle();

        // zero count allowed, unused indexes poked
        program_regs(0, 16, 10000, $urandom, $urandom, 1, 1'b1);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd0);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd3);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd16);
        queue_random(60);
        wait_idle();

        // zero bound, back-to-back traffic
        feed_steady  = 1'b1;
        drain_steady = 1'b1;
        program_regs(1, 16, 0, 32'hffffffff, 32'h0, 1, 1'b0);
        queue_random(40);
        wait_idle();

        // widest bound, max over capacity saturates
        feed_steady  = 1'b0;
        drain_steady = 1'b0;
        program_regs(16, 31, 16383, $urandom, $urandom, 1, 1'b0);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd16);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd17);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd15);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd31);
        queue_random(30);
        wait_idle();

        // catalog unavailable
        program_regs(1, 16, 10000, $urandom, $urandom, 0, 1'b0);
        queue_request(random_key(), random_key(), 16'($urandom), 8'd1);
        queue_random(20);
        wait_idle();

        // crossed limits
        drain_steady = 1'b1;
        program_regs(9, 3, 10000, $urandom, $urandom, 1, 1'b0);
        queue_random(20);
        wait_idle();

        drain_steady = 1'b0;
        feed_steady  = 1'b1;
        program_regs(1, 8, $urandom_range(0, 16383), $urandom, $urandom, 1, 1'b0);
        queue_random(120);
        wait_idle();

        feed_steady = 1'b0;
        program_regs(0, 16, 10000, $urandom, $urandom, 1, 1'b1);
        queue_random(150);
        wait_idle();

        $display("Covered %0d requests, %0d result items (%0d rejected), %0d register writes",
                 requests_taken, entries_checked, rejects_seen, cfg_writes);
        $display("Settings spanned zero and widest bounds, crossed limits and no catalog");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/spg_pkg.sv
rtl/core/spg_cfg_regs.sv
rtl/core/spg_datapath.sv
rtl/core/spg_ctrl.sv
rtl/core/seeded_splitmix_position_generator_top.sv
test/seeded_splitmix_position_generator_top_tb.sv
